[hw/rtl/bps_pkg.sv]
// Shared types, codes and the fixed pattern table of the buzzer pattern sequencer.
// No dependencies; imported by bps_step_core and buzzer_pattern_sequencer.
package bps_pkg;

    localparam int TIME_WIDTH_DEFAULT = 32;

    localparam logic [15:0] HOLD_MS = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_UPDATE  = 2'd0,
        MODE_SELECT  = 2'd1,
        MODE_SILENCE = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        TUNE_SILENT  = 3'd0,
        TUNE_BOOT    = 3'd1,
        TUNE_PASS    = 3'd2,
        TUNE_FAIL    = 3'd3,
        TUNE_IDLE    = 3'd4,
        TUNE_ARMED   = 3'd5,
        TUNE_LOCATOR = 3'd6,
        TUNE_INVALID = 3'd7
    } pattern_t;

    typedef struct packed {
        mode_t       mode;
        logic [2:0]  pattern_select;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic        tone_active;
        logic        tone_changed;
        logic [15:0] tone_hz;
        logic [2:0]  step_index;
    } out_item_t;

    // Sequencer state other than the step start time
    typedef struct packed {
        pattern_t   pattern;
        logic [2:0] step;
        logic       level;
    } seq_state_t;

    function automatic logic [2:0] pat_len(input pattern_t p);
        logic [2:0] len;
        len = 3'd1;
        case (p)
            TUNE_BOOT:    len = 3'd2;
            TUNE_PASS:    len = 3'd4;
            TUNE_FAIL:    len = 3'd6;
            TUNE_IDLE:    len = 3'd2;
            TUNE_ARMED:   len = 3'd4;
            TUNE_LOCATOR: len = 3'd2;
            default:      len = 3'd1;
        endcase
        return len;
    endfunction

    // Every pattern but silent starts on and alternates
    function automatic logic pat_on(input pattern_t p, input logic [2:0] s);
        return (p != TUNE_SILENT) && !s[0];
    endfunction

    function automatic logic [15:0] pat_ms(input pattern_t p, input logic [2:0] s);
        logic [15:0] ms;
        ms = HOLD_MS;
        case (p)
            TUNE_BOOT:    ms = (s == 3'd0) ? 16'd80 : HOLD_MS;
            TUNE_PASS:    ms = (s == 3'd3) ? HOLD_MS : 16'd80;
            TUNE_FAIL: begin
                if (s == 3'd5)
                    ms = HOLD_MS;
                else
                    ms = s[0] ? 16'd150 : 16'd400;
            end
            TUNE_IDLE:    ms = (s == 3'd0) ? 16'd50 : 16'd2950;
            TUNE_ARMED:   ms = (s == 3'd3) ? 16'd820 : 16'd60;
            TUNE_LOCATOR: ms = 16'd500;
            default:      ms = HOLD_MS;
        endcase
        return ms;
    endfunction

endpackage

[hw/rtl/bps_step_core.sv]
// Next-state logic of the sequencer: pattern table reads, a time subtract and compares.
// Depends on bps_pkg for the item types and the pattern table.
module bps_step_core import bps_pkg::*; #(
    parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
    input  in_item_t              item,
    input  seq_state_t            cur,
    input  logic [TIME_WIDTH-1:0] start_time,
    output seq_state_t            nxt,
    output logic                  load_start,
    output logic [TIME_WIDTH-1:0] now_time,
    output logic                  changed
);

    logic [15:0]           dur;
    logic [TIME_WIDTH-1:0] elapsed;
    logic [2:0]            step_inc;
    logic [2:0]            step_wrap;
    pattern_t              sel;

    assign now_time  = TIME_WIDTH'(item.now_ms);
    assign dur       = pat_ms(cur.pattern, cur.step);
    assign elapsed   = now_time - start_time;
    assign step_inc  = cur.step + 3'd1;
    assign step_wrap = (step_inc == pat_len(cur.pattern)) ? 3'd0 : step_inc;
    assign sel       = pattern_t'(item.pattern_select);

    always_comb begin
        nxt        = cur;
        load_start = 1'b0;
        unique case (item.mode)
            MODE_UPDATE: begin
                // terminal steps hold until the pattern changes
                if (dur != HOLD_MS && elapsed >= TIME_WIDTH'(dur)) begin
                    nxt.step   = step_wrap;
                    nxt.level  = pat_on(cur.pattern, step_wrap);
                    load_start = 1'b1;
                end
            end
            MODE_SELECT: begin
                if (sel != TUNE_INVALID && sel != cur.pattern) begin
                    nxt.pattern = sel;
                    nxt.step    = 3'd0;
                    nxt.level   = pat_on(sel, 3'd0);
                    load_start  = 1'b1;
                end
            end
            MODE_SILENCE: begin
                nxt.pattern = TUNE_SILENT;
                nxt.step    = 3'd0;
                nxt.level   = 1'b0;
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

    assign changed = nxt.level != cur.level;

endmodule

[hw/rtl/buzzer_pattern_sequencer.sv]
// Top level of the buzzer pattern sequencer: state, result register, config register.
// Depends on bps_pkg and bps_step_core.
//
//   channel  | ports                       | payload
//   ---------+-----------------------------+-------------------------------
//   input    | s_valid, s_ready, s_data    | in_item_t (mode, select, time)
//   result   | m_valid, m_ready, m_data    | out_item_t (tone, step, hz)
//   config   | cfg_wr_en, cfg_wr_data      | tone frequency, 16 bits
//
// One item per cycle unless stalled; a result appears the cycle after its transfer.
// The single result register is the only pipeline stage; the sequencer state
// updates in the same edge as the result register.
// A stalled result holds s_ready low until m_ready takes it; a new item is
// taken in the same cycle the held result leaves.
// aresetn clears pattern, step, start time, tone level, frequency and m_valid.
module buzzer_pattern_sequencer import bps_pkg::*; #(
    parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    seq_state_t            state_reg;
    seq_state_t            state_next;
    logic [TIME_WIDTH-1:0] start_reg;
    logic [TIME_WIDTH-1:0] now_time;
    logic                  load_start;
    logic                  changed;
    logic [15:0]           freq_reg;
    logic                  m_valid_reg;
    out_item_t             m_data_reg;
    logic                  in_xfer;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    bps_step_core #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_core (
        .item       (s_data),
        .cur        (state_reg),
        .start_time (start_reg),
        .nxt        (state_next),
        .load_start (load_start),
        .now_time   (now_time),
        .changed    (changed)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg <= '0;
        end else if (cfg_wr_en) begin
            freq_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '{pattern: TUNE_SILENT, step: 3'd0, level: 1'b0};
            start_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_xfer) begin
                state_reg <= state_next;
                if (load_start)
                    start_reg <= now_time;
            end
            if (in_xfer)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            m_data_reg.tone_active  <= state_next.level;
            m_data_reg.tone_changed <= changed;
            m_data_reg.tone_hz      <= freq_reg;
            m_data_reg.step_index   <= state_next.step;
        end
    end

    a_pattern_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.pattern != TUNE_INVALID)
        else $error("active pattern out of range");

    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.step < pat_len(state_reg.pattern))
        else $error("step beyond pattern length");

    a_silence_off: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && s_data.mode == MODE_SILENCE |=> !m_data_reg.tone_active)
        else $error("silence transfer left tone on");

    a_result_matches_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg.tone_active == state_reg.level)
        else $error("result tone level disagrees with state");

    a_changed_flips: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> m_data_reg.tone_changed == (state_reg.level != $past(state_reg.level)))
        else $error("tone_changed does not match level change");

endmodule
